// ===== rtl/core/clc_pkg.sv =====
// ----------------------------------------------------------------------------
// C-LOOK scheduler package
// Shared widths, register indexes and beat types of the C-LOOK disk scheduler.
// ----------------------------------------------------------------------------
package clc_pkg;

  localparam int CYL_W             = 16;
  localparam int MOVE_W            = 22;
  localparam int CFG_IDX_W         = 2;
  localparam int CFG_DATA_W        = 16;
  localparam int MAX_REQUESTS_DEF  = 32;
  localparam int CYLINDER_BITS_DEF = 16;
  localparam int QUEUE_DEPTH_DEF   = 4;

  localparam logic [MOVE_W-1:0] MOVE_MAX = {MOVE_W{1'b1}};

  localparam logic [CFG_IDX_W-1:0] CFG_START_POSITION = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_SWEEP_UP       = CFG_IDX_W'(1);

  typedef struct packed {
    logic [CYL_W-1:0] cylinder;
    logic             last_request;
  } in_item_t;

  typedef struct packed {
    logic [CYL_W-1:0]  served_cylinder;
    logic              last_served;
    logic [MOVE_W-1:0] total_movement;
    logic              requests_dropped;
  } out_item_t;

  typedef struct packed {
    logic [CYL_W-1:0] cylinder;
    logic             has_data;
    logic             last;
    logic             overflow;
  } qentry_t;

  typedef struct packed {
    logic [CYL_W-1:0] start_position;
    logic             sweep_up;
  } cfg_t;

endpackage

// ===== rtl/core/clc_queue.sv =====
// ----------------------------------------------------------------------------
// C-LOOK request queue
// Short register queue that decouples the request front end from the back end.
// ----------------------------------------------------------------------------
module clc_queue import clc_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  qentry_t push_data,
  output logic    full,
  input  logic    pop,
  output qentry_t pop_data,
  output logic    empty
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  qentry_t         mem_r [DEPTH];
  logic [AW-1:0]   wr_ptr_r;
  logic [AW-1:0]   rd_ptr_r;
  logic [CW-1:0]   count_r;

  assign full     = (count_r == CW'(DEPTH));
  assign empty    = (count_r == '0);
  assign pop_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + CW'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CW'(1);
      end
    end
  end

endmodule

// ===== rtl/core/clc_front.sv =====
// ----------------------------------------------------------------------------
// C-LOOK front end
// Accepts request beats, keeps the batch fill count and drops requests that
// find the batch full.
// ----------------------------------------------------------------------------
module clc_front import clc_pkg::*; #(
  parameter int MAX_REQUESTS  = MAX_REQUESTS_DEF,
  parameter int CYLINDER_BITS = CYLINDER_BITS_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_item_t in_data,
  output logic     q_push,
  output qentry_t  q_data,
  input  logic     q_full
);

  localparam int SW = (CYLINDER_BITS < CYL_W) ? CYLINDER_BITS : CYL_W;
  localparam int CW = $clog2(MAX_REQUESTS + 1);

  logic [CW-1:0] count_r;
  logic          ovf_r;
  logic          acc;
  logic          room;

  assign in_stall = q_full;
  assign acc      = in_valid && !q_full;
  assign room     = (count_r != CW'(MAX_REQUESTS));
  assign q_push   = acc && (room || in_data.last_request);

  always_comb begin
    q_data.cylinder = CYL_W'(in_data.cylinder[SW-1:0]);
    q_data.has_data = room;
    q_data.last     = in_data.last_request;
    q_data.overflow = ovf_r || !room;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      ovf_r   <= 1'b0;
    end else if (acc) begin
      if (in_data.last_request) begin
        count_r <= '0;
        ovf_r   <= 1'b0;
      end else if (room) begin
        count_r <= count_r + CW'(1);
      end else begin
        ovf_r <= 1'b1;
      end
    end
  end

endmodule

// ===== rtl/core/clc_back.sv =====
// ----------------------------------------------------------------------------
// C-LOOK back end
// Insertion-sorts queued requests into a row of cells, finds the split at the
// head position and emits the batch in C-LOOK order with the head movement.
// ----------------------------------------------------------------------------
module clc_back import clc_pkg::*; #(
  parameter int MAX_REQUESTS  = MAX_REQUESTS_DEF,
  parameter int CYLINDER_BITS = CYLINDER_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  output logic      q_pop,
  input  qentry_t   q_data,
  input  logic      q_empty,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  localparam int SW = (CYLINDER_BITS < CYL_W) ? CYLINDER_BITS : CYL_W;
  localparam int CW = $clog2(MAX_REQUESTS + 1);
  localparam int IW = $clog2(MAX_REQUESTS);

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SCAN,
    ST_EMIT
  } state_t;

  state_t            state_r;
  logic [SW-1:0]     row_r [MAX_REQUESTS];
  logic [SW-1:0]     ins_v [MAX_REQUESTS];
  logic              le    [MAX_REQUESTS];
  logic [CW-1:0]     cnt_r;
  logic [CW-1:0]     idx_r;
  logic [CW-1:0]     rem_r;
  logic              first_r;
  logic [SW-1:0]     prev_r;
  logic [MOVE_W-1:0] move_r;
  logic              ovf_r;
  logic              out_valid_r;
  out_item_t         out_data_r;

  logic [SW-1:0]     key;
  logic [SW-1:0]     head;
  logic [SW-1:0]     rd_v;
  logic [SW-1:0]     diff;
  logic [MOVE_W:0]   sum;
  logic [MOVE_W-1:0] move_step;
  logic              scan_hit;
  logic [CW-1:0]     start_idx;
  logic [CW-1:0]     next_idx;
  logic              out_free;
  logic              is_last;

  assign key       = q_data.cylinder[SW-1:0];
  assign head      = cfg.start_position[SW-1:0];
  assign rd_v      = row_r[idx_r[IW-1:0]];
  assign q_pop     = (state_r == ST_LOAD) && !q_empty;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign is_last   = (rem_r == CW'(1));

  always_comb begin
    for (int i = 0; i < MAX_REQUESTS; i++) begin
      le[i] = (CW'(i) < cnt_r) && (row_r[i] <= key);
    end
    ins_v[0] = le[0] ? row_r[0] : key;
    for (int i = 1; i < MAX_REQUESTS; i++) begin
      ins_v[i] = le[i] ? row_r[i] : (le[i-1] ? key : row_r[i-1]);
    end
  end

  always_comb begin
    diff      = (rd_v >= prev_r) ? rd_v - prev_r : prev_r - rd_v;
    sum       = {1'b0, move_r} + (MOVE_W + 1)'(diff);
    move_step = first_r ? '0 : (sum[MOVE_W] ? MOVE_MAX : sum[MOVE_W-1:0]);
    scan_hit  = (idx_r == cnt_r) || (rd_v >= head);
    if (cfg.sweep_up) begin
      start_idx = (idx_r == cnt_r) ? '0 : idx_r;
      next_idx  = (idx_r == cnt_r - CW'(1)) ? '0 : idx_r + CW'(1);
    end else begin
      start_idx = (idx_r == '0) ? cnt_r - CW'(1) : idx_r - CW'(1);
      next_idx  = (idx_r == '0) ? cnt_r - CW'(1) : idx_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && q_data.has_data) begin
      row_r <= ins_v;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      cnt_r       <= '0;
      idx_r       <= '0;
      rem_r       <= '0;
      first_r     <= 1'b1;
      prev_r      <= '0;
      move_r      <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
      out_data_r  <= '0;
    end else begin
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_LOAD: begin
          if (q_pop) begin
            if (q_data.has_data) begin
              cnt_r <= cnt_r + CW'(1);
            end
            if (q_data.last) begin
              ovf_r   <= q_data.overflow;
              idx_r   <= '0;
              state_r <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          if (scan_hit) begin
            idx_r   <= start_idx;
            rem_r   <= cnt_r;
            first_r <= 1'b1;
            move_r  <= '0;
            state_r <= ST_EMIT;
          end else begin
            idx_r <= idx_r + CW'(1);
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            out_valid_r                 <= 1'b1;
            out_data_r.served_cylinder  <= CYL_W'(rd_v);
            out_data_r.last_served      <= is_last;
            out_data_r.total_movement   <= is_last ? move_step : '0;
            out_data_r.requests_dropped <= ovf_r;
            prev_r  <= rd_v;
            move_r  <= move_step;
            first_r <= 1'b0;
            rem_r   <= rem_r - CW'(1);
            idx_r   <= next_idx;
            if (is_last) begin
              cnt_r   <= '0;
              state_r <= ST_LOAD;
            end
          end
        end
        default: begin
          state_r <= ST_LOAD;
        end
      endcase
    end
  end

endmodule

// ===== rtl/core/c_look_disk_scheduler_top.sv =====
// ----------------------------------------------------------------------------
// C-LOOK disk scheduler
// Collects a batch of cylinder requests and serves them in C-LOOK order.
// ----------------------------------------------------------------------------
// Request beats are taken into a four-entry queue one per cycle while it is
// not full. The back end drains that queue one request per cycle while in
// its load state, insertion-sorting it into a row of cells. After the marked
// request it scans the sorted row for the first request at or above the
// head, and then emits one served cylinder per cycle while the output is
// not stalled. Requests of the next batch are taken during this time until
// the queue is full. The movement total on the final beat counts only the
// moves between served cylinders and saturates at its maximum.
// Configuration is taken at any time, but should only change while idle.
module c_look_disk_scheduler_top import clc_pkg::*; #(
  parameter int MAX_REQUESTS  = MAX_REQUESTS_DEF,
  parameter int CYLINDER_BITS = CYLINDER_BITS_DEF,
  parameter int QUEUE_DEPTH   = QUEUE_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t    cfg_r;
  logic    q_push;
  logic    q_full;
  logic    q_pop;
  logic    q_empty;
  qentry_t q_wdata;
  qentry_t q_rdata;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_position <= '0;
      cfg_r.sweep_up       <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_START_POSITION: cfg_r.start_position <= cfg_data[CYL_W-1:0];
        CFG_SWEEP_UP:       cfg_r.sweep_up       <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  clc_front #(
    .MAX_REQUESTS  (MAX_REQUESTS),
    .CYLINDER_BITS (CYLINDER_BITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_push   (q_push),
    .q_data   (q_wdata),
    .q_full   (q_full)
  );

  clc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .empty     (q_empty)
  );

  clc_back #(
    .MAX_REQUESTS  (MAX_REQUESTS),
    .CYLINDER_BITS (CYLINDER_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_pop     (q_pop),
    .q_data    (q_rdata),
    .q_empty   (q_empty),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // A stalled result beat keeps its payload until it is taken.
  a_stall_holds_beat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("stalled result beat changed");

  a_drop_flag_held: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && !out_data.last_served) |=>
    (!out_valid || (out_data.requests_dropped == $past(out_data.requests_dropped))))
    else $error("drop flag changed within a batch");

  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

// ===== verif/tb_c_look_disk_scheduler_top.sv =====
// ----------------------------------------------------------------------------
// C-LOOK disk scheduler testbench
// Sends batches of cylinder requests, works out the expected served order,
// the batch movement and the dropped flag of each batch, and checks every
// result beat against them under varying head positions, sweep directions,
// idle gaps, stalls and one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_c_look_disk_scheduler_top;
  import clc_pkg::*;

  localparam int BATCH_SLOTS   = MAX_REQUESTS_DEF;
  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = 80;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  in_item_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_START_POSITION;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  in_item_t    pending_requests[$];
  out_item_t   served_expected[$];
  out_item_t   oldest_served;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  bit          hold_arm       = 1'b0;
  bit          hold_active    = 1'b0;
  bit          in_taken       = 1'b0;
  int          mismatch_count = 0;

  logic [CYL_W-1:0]  batch_store [BATCH_SLOTS];
  int                batch_len     = 0;
  bit                batch_dropped = 1'b0;
  logic [CYL_W-1:0]  head_position = '0;
  bit                sweep_upward  = 1'b1;
  logic [CYL_W-1:0]  last_served_cyl = '0;
  logic [MOVE_W-1:0] movement_sum  = '0;

  c_look_disk_scheduler_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    mismatch_count++;
    $display("mismatch on %s: got %0d, expected %0d (t=%0t)", what, got, want, $time);
  endtask

  // Stores one request and, on the marked one, works out the served order.
  task automatic schedule_request(input in_item_t req);
    logic [CYL_W-1:0] sorted [BATCH_SLOTS];
    logic [CYL_W-1:0] order [BATCH_SLOTS];
    logic [CYL_W-1:0] key;
    int               i, j, split, cnt;
    int unsigned      diff;
    out_item_t        beat;
    if (batch_len < BATCH_SLOTS) begin
      batch_store[batch_len] = req.cylinder;
      batch_len++;
    end else begin
      batch_dropped = 1'b1;
    end
    if (!req.last_request) return;
    for (i = 0; i < batch_len; i++) begin
      key = batch_store[i];
      j = i;
      while (j > 0 && sorted[j-1] > key) begin
        sorted[j] = sorted[j-1];
        j--;
      end
      sorted[j] = key;
    end
    split = batch_len;
    for (i = batch_len - 1; i >= 0; i--) begin
      if (sorted[i] >= head_position) split = i;
    end
    cnt = 0;
    if (sweep_upward) begin
      for (i = split; i < batch_len; i++) order[cnt++] = sorted[i];
      for (i = 0; i < split; i++) order[cnt++] = sorted[i];
    end else begin
      for (i = split - 1; i >= 0; i--) order[cnt++] = sorted[i];
      for (i = batch_len - 1; i >= split; i--) order[cnt++] = sorted[i];
    end
    movement_sum = '0;
    for (i = 0; i < cnt; i++) begin
      if (i > 0) begin
        diff = (order[i] >= last_served_cyl) ? 32'(order[i] - last_served_cyl)
                                             : 32'(last_served_cyl - order[i]);
        if (diff > int'(MOVE_MAX - movement_sum)) movement_sum = MOVE_MAX;
        else movement_sum = movement_sum + MOVE_W'(diff);
      end
      last_served_cyl = order[i];
      beat.served_cylinder  = order[i];
      beat.last_served      = (i == cnt - 1);
      beat.total_movement   = (i == cnt - 1) ? movement_sum : '0;
      beat.requests_dropped = batch_dropped;
      served_expected.push_back(beat);
    end
    batch_len = 0;
    batch_dropped = 1'b0;
  endtask

  always @(posedge clk) begin
    in_taken = rst_n && in_valid && !in_stall;
    if (in_taken) schedule_request(in_data);
    if (rst_n && out_valid && !out_stall) begin
      if (served_expected.size() == 0) begin
        report_mismatch("result beat with nothing expected",
                        32'(out_data.served_cylinder), 0);
      end else begin
        oldest_served = served_expected.pop_front();
        if (out_data.served_cylinder !== oldest_served.served_cylinder)
          report_mismatch("served_cylinder", 32'(out_data.served_cylinder),
                          32'(oldest_served.served_cylinder));
        if (out_data.last_served !== oldest_served.last_served)
          report_mismatch("last_served", 32'(out_data.last_served),
                          32'(oldest_served.last_served));
        if (out_data.total_movement !== oldest_served.total_movement)
          report_mismatch("total_movement", 32'(out_data.total_movement),
                          32'(oldest_served.total_movement));
        if (out_data.requests_dropped !== oldest_served.requests_dropped)
          report_mismatch("requests_dropped", 32'(out_data.requests_dropped),
                          32'(oldest_served.requests_dropped));
      end
    end
  end

  always @(negedge clk) begin
    if (!in_valid || in_taken) begin
      if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_data  <= pending_requests.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_stall <= hold_active || ($urandom_range(99) < recv_stall_pct);
  end

  // The receiver holds off for a long stretch while requests keep coming.
  initial begin
    wait (hold_arm);
    @(posedge clk);
    hold_active = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_active = 1'b0;
  end

  task automatic set_registers(input logic [CYL_W-1:0] head_pos, input bit up);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_START_POSITION;
    cfg_data  <= head_pos;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    head_position = head_pos;
    @(negedge clk);
    cfg_index <= CFG_SWEEP_UP;
    cfg_data  <= CFG_DATA_W'(up);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sweep_upward = up;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic add_request(input logic [CYL_W-1:0] cyl, input bit last);
    in_item_t req;
    req.cylinder     = cyl;
    req.last_request = last;
    pending_requests.push_back(req);
  endtask

  function automatic logic [CYL_W-1:0] pick_cylinder();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return head_position + CYL_W'($urandom_range(0, 3)) - CYL_W'(1);
      default: return CYL_W'($urandom);
    endcase
  endfunction

  task automatic add_batch(input int len);
    int k;
    for (k = 0; k < len; k++) add_request(pick_cylinder(), k == len - 1);
  endtask

  task automatic add_random_batches(input int quota);
    int added, len;
    added = 0;
    while (added < quota) begin
      case ($urandom_range(0, 15))
        0:       len = $urandom_range(BATCH_SLOTS, BATCH_SLOTS + 4);
        1, 2:    len = $urandom_range(9, BATCH_SLOTS - 1);
        default: len = $urandom_range(1, 8);
      endcase
      add_batch(len);
      added += len;
    end
  endtask

  task automatic wait_drained();
    while (pending_requests.size() != 0 || in_valid || served_expected.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_random_phase(input logic [CYL_W-1:0] head_pos, input bit up,
                                  input int unsigned send_pct,
                                  input int unsigned recv_pct);
    set_registers(head_pos, up);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    add_random_batches(30);
    wait_drained();
  endtask

  initial begin
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    set_registers(16'd100, 1'b1);
    add_request(16'd100, 1'b1);
    add_request(16'd65535, 1'b0);
    add_request(16'd0, 1'b0);
    add_request(16'd101, 1'b0);
    add_request(16'd99, 1'b0);
    add_request(16'd100, 1'b1);
    add_request(16'd5, 1'b0);
    add_request(16'd50, 1'b0);
    add_request(16'd99, 1'b1);
    add_request(16'd0, 1'b1);
    add_request(16'd65535, 1'b1);
    add_request(16'd7, 1'b0);
    add_request(16'd7, 1'b0);
    add_request(16'd200, 1'b0);
    add_request(16'd7, 1'b1);
    wait_drained();

    run_random_phase(16'd0, 1'b0, 0, 0);
    run_random_phase(16'd65535, 1'b1, 48, 0);
    run_random_phase(CYL_W'($urandom), 1'b0, 0, 48);
    run_random_phase(CYL_W'($urandom), 1'b1, 11, 11);

    set_registers(16'd32768, 1'b0);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_arm = 1'b1;
    add_batch(BATCH_SLOTS + 2);
    add_random_batches(30);
    wait_drained();

    run_random_phase(16'd65535, 1'b0, 48, 48);

    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("status: fail");
    $finish;
  end

endmodule
